/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* src/rau_pkg.sv */
package rau_pkg;
  localparam int WORD_BITS = 64;
  localparam int WIDE_BITS = 2 * WORD_BITS;
  localparam int SHIFT_BITS = 8;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  // Command to the shared 64x64 multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;
endpackage

/* src/rau_mul.sv */
// 64x64 unsigned multiplier built from one 32x32 multiplier over four partial products.
`include "assert_macros.svh"
module rau_mul (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::mul_req_t req,
  output rau_pkg::mul_rsp_t rsp
);
  logic [63:0]  a;
  logic [63:0]  b;
  logic [2:0]   step;
  logic         run;
  logic [63:0]  part;
  logic [127:0] acc;
  logic [31:0]  xa;
  logic [31:0]  xb;
  logic [6:0]   sh;

  // Pick the halves for the current partial product.
  always_comb begin
    xa = step[0] ? a[63:32] : a[31:0];
    xb = step[1] ? b[63:32] : b[31:0];
  end

  // Offset of the partial product that sits in part, taken one step late.
  always_comb begin
    unique case (step)
      3'd1: sh = 7'd0;
      3'd2, 3'd3: sh = 7'd32;
      default: sh = 7'd64;
    endcase
  end

  // Partial product is registered, then accumulated at its offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      step <= 3'd0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.start && run && (step == 3'd4);
      if (req.start) begin
        a <= req.a;
        b <= req.b;
        run <= 1'b1;
        step <= 3'd0;
        acc <= '0;
      end else if (run) begin
        part <= xa * xb;
        step <= step + 3'd1;
        if (step == 3'd4) begin
          run <= 1'b0;
          rsp.p <= acc + ({64'd0, part} << sh);
        end else if (step != 3'd0) begin
          acc <= acc + ({64'd0, part} << sh);
        end
      end
    end
  end

  `ASSERT_IMPL(a_mul_step, clk, rst, (run |-> step <= 3'd4), "multiplier step out of range")
  `ASSERT_IMPL(a_mul_done, clk, rst, (rsp.done |-> !run), "multiplier done while running")
  `ASSERT_IMPL(a_mul_start, clk, rst, (req.start |=> run), "multiplier did not start")
endmodule

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit. Pulse start while busy is low with an operation and two
// fractions; busy rises and, when the work is done, valid pulses for one cycle with the
// reduced result or the compare flags, and status. The receiver cannot stall: capture the
// result in that cycle. An item runs the three products one after another on the shared
// multiplier, then a binary gcd and two restoring divisions (numerator, then denominator),
// all on shared serial datapaths. Compare finishes right after the products, and a zero
// denominator or divisor skips the products and finishes with ST_ZERO status.
`include "assert_macros.svh"
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [63:0] a_num,
  input  logic signed [63:0] a_den,
  input  logic signed [63:0] b_num,
  input  logic signed [63:0] b_den,
  output logic               valid,
  output logic signed [63:0] res_num,
  output logic [62:0]        res_den,
  output logic               is_less,
  output logic               is_equal,
  output logic [1:0]         status
);
  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_ADD, S_CMP, S_G0, S_G1, S_G2, S_G3,
    S_DN, S_DD, S_FIN
  } state_t;

  state_t state;
  logic [2:0] op;
  logic na, nad, nb, nbd;
  logic [63:0] man, mad, mbn, mbd;
  logic [127:0] p0, p1, p2;
  logic [127:0] nm, dm, ga, gb, q, r;
  logic nneg, dneg, neg;
  logic [7:0] k;
  logic [6:0] cnt;
  logic [127:0] ddiv;
  rau_pkg::mul_req_t mreq;
  rau_pkg::mul_rsp_t mrsp;
  logic [1:0] midx;
  logic [127:0] rsh;
  logic [127:0] qn;
  logic [127:0] top;
  logic zero_div;

  assign top = {64'd0, 1'b1, 63'd0};
  // Shift the next dividend bit into the partial remainder.
  assign rsh = {r[126:0], ddiv[cnt]};
  assign qn = {q[126:0], (rsh >= ga)};
  assign zero_div = (mad == '0) || (mbd == '0) || (op == rau_pkg::OP_DIV && mbn == '0);

  rau_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  // Sequencer for products, compare, gcd and divisions.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      valid <= 1'b0;
      mreq.start <= 1'b0;
    end else begin
      valid <= (state == S_FIN);
      mreq.start <= (state == S_M0) && !zero_div;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            op <= operation;
            na <= a_num[63]; nad <= a_den[63]; nb <= b_num[63]; nbd <= b_den[63];
            man <= mag(a_num); mad <= mag(a_den); mbn <= mag(b_num); mbd <= mag(b_den);
            res_num <= '0; res_den <= '0; is_less <= 1'b0; is_equal <= 1'b0;
            status <= rau_pkg::ST_OK;
            midx <= 2'd0;
            state <= S_M0;
          end
        end
        S_M0: begin
          if (zero_div) begin
            status <= rau_pkg::ST_ZERO;
            state <= S_FIN;
          end else begin
            // p0 = first num product, p1 = second, p2 = den product.
            unique case (midx)
              2'd0: begin
                mreq.a <= man;
                mreq.b <= (op == rau_pkg::OP_MUL) ? mbn : mbd;
              end
              2'd1: begin mreq.a <= mbn; mreq.b <= mad; end
              default: begin
                mreq.a <= mad;
                mreq.b <= (op == rau_pkg::OP_DIV) ? mbn : mbd;
              end
            endcase
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          if (mrsp.done) begin
            unique case (midx)
              2'd0: p0 <= mrsp.p;
              2'd1: p1 <= mrsp.p;
              default: p2 <= mrsp.p;
            endcase
            midx <= midx + 2'd1;
            if (midx == 2'd2) state <= (op >= rau_pkg::OP_CMP) ? S_CMP : S_ADD;
            else state <= S_M0;
          end
        end
        S_CMP: begin
          // Signs: left = (na^nad), right = (nb^nbd); zero magnitude is nonnegative.
          begin
            logic ln, rn;
            ln = (na ^ nad) && (p0 != '0);
            rn = (nb ^ nbd) && (p1 != '0);
            if (ln != rn) is_less <= ln;
            else is_less <= ln ? (p0 > p1) : (p0 < p1);
            is_equal <= (ln == rn) && (p0 == p1);
          end
          state <= S_FIN;
        end
        S_ADD: begin
          begin
            logic s0, s1;
            s0 = (op == rau_pkg::OP_MUL) ? (na ^ nb) : (na ^ nbd);
            s1 = (nb ^ nad) ^ (op == rau_pkg::OP_SUB);
            if (op == rau_pkg::OP_MUL || op == rau_pkg::OP_DIV) begin
              nm <= p0; nneg <= s0;
            end else if (s0 == s1) begin
              nm <= p0 + p1; nneg <= s0;
            end else if (p0 >= p1) begin
              nm <= p0 - p1; nneg <= s0;
            end else begin
              nm <= p1 - p0; nneg <= s1;
            end
            dm <= p2;
            dneg <= (op == rau_pkg::OP_DIV) ? (nad ^ nb) : (nad ^ nbd);
          end
          state <= S_G0;
        end
        S_G0: begin
          neg <= (nneg != dneg) && (nm != '0);
          gb <= p2; k <= '0;
          if (nm == '0) begin
            // A zero numerator reduces by the denominator itself.
            ga <= p2; cnt <= 7'd127; r <= '0; q <= '0; ddiv <= nm;
            state <= S_DN;
          end else begin
            ga <= nm; state <= S_G1;
          end
        end
        S_G1: begin
          // Strip common factors of two.
          if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1; gb <= gb >> 1; k <= k + 8'd1;
          end else state <= S_G2;
        end
        S_G2: begin
          if (!ga[0]) ga <= ga >> 1;
          else if (!gb[0]) gb <= gb >> 1;
          else state <= S_G3;
        end
        S_G3: begin
          // One shift or subtract step of the binary gcd; both odd when subtracting.
          if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga == gb) begin
            ga <= ga << k; cnt <= 7'd127; r <= '0; q <= '0; ddiv <= nm;
            state <= S_DN;
          end else if (ga > gb) begin
            ga <= gb; gb <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
        S_DN, S_DD: begin
          // Restoring division, one bit a cycle; ga holds the gcd.
          if (cnt == 7'd0) begin
            if (state == S_DN) begin
              nm <= qn;
              ddiv <= dm; r <= '0; q <= '0; cnt <= 7'd127;
              state <= S_DD;
            end else begin
              dm <= qn;
              state <= S_FIN;
            end
          end else begin
            r <= (rsh >= ga) ? (rsh - ga) : rsh;
            q <= qn;
            cnt <= cnt - 7'd1;
          end
        end
        S_FIN: begin
          if (status == rau_pkg::ST_OK && op < rau_pkg::OP_CMP) begin
            if (nm > (neg ? top : top - 128'd1) || dm > top - 128'd1) begin
              status <= rau_pkg::ST_OVF;
            end else begin
              res_num <= neg ? (64'd0 - nm[63:0]) : nm[63:0];
              res_den <= dm[62:0];
            end
          end
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_busy_idle, clk, rst, (state == S_IDLE |-> !busy), "busy while idle")
  `ASSERT_IMPL(a_valid_end, clk, rst, (valid |-> !busy), "result while busy")
  `ASSERT_IMPL(a_ovf_zero, clk, rst, (valid && status != rau_pkg::ST_OK |-> res_num == 0),
    "error result not cleared")
endmodule
